// ----- hw/rtl/dsa_pkg.sv -----
// Types, codes and constants shared by the descriptor slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

   localparam int DSA_MAX_SLOTS   = 1024;  // default stack depth
   localparam int ADDR_BITS       = 64;
   localparam int SIZE_BITS       = 16;
   localparam int COUNT_BITS      = 11;
   localparam int SLOT_BITS       = 10;
   localparam int KIND_BITS       = 3;
   localparam int CSR_IDX_BITS    = 3;
   localparam int MUL_IDX_BITS    = 11;    // any in-range slot index is below 2048
   localparam int PROD_BITS       = MUL_IDX_BITS + SIZE_BITS;
   localparam int DIV_LONG_STEPS  = ADDR_BITS;
   localparam int DIV_SHORT_STEPS = MUL_IDX_BITS;
   localparam int DIV_CNT_BITS    = $clog2(DIV_LONG_STEPS + 1);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ALLOC    = 3'd0,
      KIND_FREE     = 3'd1,
      KIND_VALIDATE = 3'd2,
      KIND_IDX2HND  = 3'd3,
      KIND_HND2IDX  = 3'd4,
      KIND_REINIT   = 3'd5
   } dsa_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_EMPTY    = 2'd1,
      ERR_RANGE    = 2'd2,
      ERR_OVERFLOW = 2'd3
   } dsa_err_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CPU_BASE       = 3'd0,
      CSR_GPU_BASE       = 3'd1,
      CSR_SLOT_SIZE      = 3'd2,
      CSR_SLOT_COUNT     = 3'd3,
      CSR_SHADER_VISIBLE = 3'd4
   } dsa_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_EVAL,
      ST_DIV,
      ST_GCHK,
      ST_MUL,
      ST_ADDR,
      ST_RESULT
   } dsa_state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [ADDR_BITS-1:0] cpu_addr;
      logic [ADDR_BITS-1:0] gpu_addr;
      logic [SLOT_BITS-1:0] slot_index;
   } dsa_req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] cpu_handle;
      logic [ADDR_BITS-1:0] gpu_handle;
      logic [SLOT_BITS-1:0] slot_out;
      logic                 ok;
      logic [1:0]           error;
   } dsa_rsp_type;

   typedef struct packed {
      logic                 start;
      logic                 short_run;  // quotient known to fit in MUL_IDX_BITS
      logic [ADDR_BITS-1:0] dividend;
      logic [SIZE_BITS-1:0] divisor;
   } dsa_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [ADDR_BITS-1:0] quotient;
      logic [SIZE_BITS-1:0] remainder;
   } dsa_div_rsp_type;

   function automatic dsa_rsp_type make_rsp(
      input logic [ADDR_BITS-1:0] cpu_handle,
      input logic [ADDR_BITS-1:0] gpu_handle,
      input logic [SLOT_BITS-1:0] slot_out,
      input logic                 ok,
      input dsa_err_type          error
   );
      dsa_rsp_type rsp;
      rsp.cpu_handle = cpu_handle;
      rsp.gpu_handle = gpu_handle;
      rsp.slot_out   = slot_out;
      rsp.ok         = ok;
      rsp.error      = error;
      return rsp;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/descriptor_slot_allocator.sv -----
// Top level of the descriptor slot allocator: request sequencer, registers, result stage.
//
// Hands out and takes back fixed-size descriptor slots through a LIFO free list.
// req_*: one request beat (alloc, free, validate, index to handle, handle to
//    index, reinit); req_ready is high only while no request is in flight.
// rsp_*: exactly one result beat per request, held in an output register.
// csr_*: register writes (cpu_base, gpu_base, slot_size, slot_count,
//    shader_visible), always ready; write only while no request is in flight.
// Sequencer states from request accept to result valid:
//    alloc, index to handle: PREP, EVAL, MUL, ADDR, RESULT; reinit and early
//    errors: PREP, EVAL, RESULT; validate, handle to index, in-range free:
//    PREP, EVAL, DIV (11-step iterative divider), GCHK for a free only, RESULT;
//    out-of-range free: no GCHK; DIV runs all 64 quotient bits to report low slot bits.
// One request at a time; the next request is taken as soon as its result
// sits in the output register, even if rsp_ready is low.
// A stalled receiver holds the result in place; a further result waits in
// the sequencer until the output register empties.
// Reset clears the counters and restores register defaults; the free-stack
// memory needs no clearing since only entries below the stack depth are read.
`timescale 1ns / 1ps
`default_nettype none

module descriptor_slot_allocator
   import dsa_pkg::*;
#(
   parameter int MAX_SLOTS = DSA_MAX_SLOTS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire dsa_req_type             req_payload,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output dsa_rsp_type                  rsp_payload,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [ADDR_BITS-1:0]    csr_wdata
);

   localparam int CNT_MAX = (MAX_SLOTS < 2047) ? MAX_SLOTS : 2047;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int IDX_W   = $clog2(CNT_MAX);
   localparam int DEPTH_W = $clog2(MAX_SLOTS + 1);
   localparam int ADDR_W  = $clog2(MAX_SLOTS);
   localparam int LIM_W   = CNT_W + SIZE_BITS;

   // configuration
   logic [ADDR_BITS-1:0]  cpu_base_ff, cpu_base_in;
   logic [ADDR_BITS-1:0]  gpu_base_ff, gpu_base_in;
   logic [SIZE_BITS-1:0]  slot_size_ff, slot_size_in;
   logic [COUNT_BITS-1:0] slot_count_ff, slot_count_in;
   logic                  shader_visible_ff, shader_visible_in;

   // sequencer and allocator state
   dsa_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      fresh_ff, fresh_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;

   // working registers
   dsa_req_type           req_ff, req_in;
   logic [ADDR_BITS-1:0]  off_ff, off_in;
   logic [ADDR_BITS-1:0]  goff_ff, goff_in;
   logic                  below_ff, below_in;
   logic [LIM_W-1:0]      limit_ff, limit_in;
   logic                  inr_ff, inr_in;
   logic [MUL_IDX_BITS-1:0] q_ff, q_in;
   logic [ADDR_BITS-1:0]  qs_ff, qs_in;
   logic [MUL_IDX_BITS-1:0] idx_ff, idx_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   dsa_rsp_type           res_ff, res_in;
   dsa_rsp_type           rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // shared decode
   logic [CNT_W-1:0]      eff_cnt;
   logic                  inr;
   logic                  can_pop;
   logic                  can_fresh;
   logic                  val_fail;
   logic                  h2i_fail;
   logic [ADDR_BITS-1:0]  gdiff;
   logic                  gmatch;
   logic                  gbad;
   logic                  stack_full;
   logic                  out_free;
   logic                  req_take;
   logic [ADDR_BITS-1:0]  cpu_form;
   logic [ADDR_BITS-1:0]  gpu_form;
   logic                  i2h_ok;

   // submodule links
   dsa_div_req_type       div_req;
   dsa_div_rsp_type       div_rsp;
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [IDX_W-1:0]      mem_wr_data;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [IDX_W-1:0]      mem_rd_data;

   dsa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dsa_stack_mem #(
      .DEPTH  (MAX_SLOTS),
      .DATA_W (IDX_W)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      eff_cnt    = (32'(slot_count_ff) < MAX_SLOTS) ? CNT_W'(slot_count_ff)
                                                    : CNT_W'(MAX_SLOTS);
      inr        = off_ff < ADDR_BITS'(limit_ff);
      can_pop    = depth_ff != '0;
      can_fresh  = fresh_ff < eff_cnt;
      val_fail   = below_ff || !inr ||
                   ((req_ff.gpu_addr != '0) && (goff_ff != off_ff));
      h2i_fail   = below_ff || !inr;
      // GPU quotient equals q when q*size <= goff < q*size + size
      gdiff      = goff_ff - qs_ff;
      gmatch     = (goff_ff >= qs_ff) && (gdiff < ADDR_BITS'(slot_size_ff));
      gbad       = (req_ff.gpu_addr != '0) && !gmatch;
      stack_full = depth_ff == DEPTH_W'(MAX_SLOTS);
      out_free   = !rsp_valid_ff || rsp_ready;
      req_take   = req_valid && (state_ff == ST_IDLE);
      cpu_form   = (cpu_base_ff == '0) ? '0 : cpu_base_ff + ADDR_BITS'(prod_ff);
      gpu_form   = (!shader_visible_ff || gpu_base_ff == '0) ? '0
                                              : gpu_base_ff + ADDR_BITS'(prod_ff);
      i2h_ok     = 32'(req_ff.slot_index) < 32'(eff_cnt);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_EVAL;
         ST_EVAL: begin
            unique case (req_ff.kind)
               KIND_ALLOC:    state_in = (can_pop || can_fresh) ? ST_MUL : ST_RESULT;
               KIND_FREE:     state_in = below_ff ? ST_RESULT : ST_DIV;
               KIND_VALIDATE: state_in = val_fail ? ST_RESULT : ST_DIV;
               KIND_HND2IDX:  state_in = h2i_fail ? ST_RESULT : ST_DIV;
               KIND_IDX2HND:  state_in = ST_MUL;
               default:       state_in = ST_RESULT;
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = (req_ff.kind == KIND_FREE && inr_ff) ? ST_GCHK : ST_RESULT;
            end
         end
         ST_GCHK:   state_in = ST_RESULT;
         ST_MUL:    state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      req_in       = req_ff;
      off_in       = off_ff;
      goff_in      = goff_ff;
      below_in     = below_ff;
      limit_in     = limit_ff;
      inr_in       = inr_ff;
      q_in         = q_ff;
      qs_in        = qs_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      fresh_in     = fresh_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;

      div_req.start     = 1'b0;
      div_req.short_run = inr;
      div_req.dividend  = off_ff;
      div_req.divisor   = slot_size_ff;

      mem_rd_en   = 1'b0;
      mem_rd_addr = ADDR_W'(depth_ff - DEPTH_W'(1));
      mem_wr_en   = 1'b0;
      mem_wr_addr = ADDR_W'(depth_ff);
      mem_wr_data = IDX_W'(q_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) req_in = req_payload;
         end
         ST_PREP: begin
            off_in    = req_ff.cpu_addr - cpu_base_ff;
            goff_in   = req_ff.gpu_addr - gpu_base_ff;
            below_in  = req_ff.cpu_addr < cpu_base_ff;
            limit_in  = LIM_W'(eff_cnt) * LIM_W'(slot_size_ff);
            mem_rd_en = (req_ff.kind == KIND_ALLOC) && can_pop;
         end
         ST_EVAL: begin
            inr_in = inr;
            unique case (req_ff.kind)
               KIND_ALLOC: begin
                  if (can_pop) begin
                     idx_in   = MUL_IDX_BITS'(mem_rd_data);
                     depth_in = depth_ff - DEPTH_W'(1);
                  end else if (can_fresh) begin
                     idx_in   = MUL_IDX_BITS'(fresh_ff);
                     fresh_in = fresh_ff + CNT_W'(1);
                  end else begin
                     res_in = make_rsp('0, '0, '0, 1'b0, ERR_EMPTY);
                  end
               end
               KIND_FREE: begin
                  if (below_ff) res_in = make_rsp('0, '0, '0, 1'b0, ERR_RANGE);
                  else          div_req.start = 1'b1;
               end
               KIND_VALIDATE: begin
                  if (val_fail) res_in = make_rsp('0, '0, '0, 1'b0, ERR_RANGE);
                  else          div_req.start = 1'b1;
               end
               KIND_HND2IDX: begin
                  if (h2i_fail) res_in = make_rsp('0, '0, '0, 1'b0, ERR_RANGE);
                  else          div_req.start = 1'b1;
               end
               KIND_IDX2HND: begin
                  idx_in = MUL_IDX_BITS'(req_ff.slot_index);
               end
               KIND_REINIT: begin
                  fresh_in = '0;
                  depth_in = '0;
                  res_in   = make_rsp('0, '0, '0, 1'b1, ERR_NONE);
               end
               default: begin
                  res_in = make_rsp('0, '0, '0, 1'b0, ERR_RANGE);
               end
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (req_ff.kind == KIND_FREE) begin
                  q_in  = MUL_IDX_BITS'(div_rsp.quotient);
                  qs_in = off_ff - ADDR_BITS'(div_rsp.remainder);
                  // out of range: report the low quotient bits
                  res_in = make_rsp('0, '0, SLOT_BITS'(div_rsp.quotient), 1'b0, ERR_RANGE);
               end else begin
                  res_in = make_rsp('0, '0, SLOT_BITS'(div_rsp.quotient), 1'b1, ERR_NONE);
               end
            end
         end
         ST_GCHK: begin
            if (gbad) begin
               res_in = make_rsp('0, '0, SLOT_BITS'(q_ff), 1'b0, ERR_RANGE);
            end else if (stack_full) begin
               res_in = make_rsp('0, '0, SLOT_BITS'(q_ff), 1'b0, ERR_OVERFLOW);
            end else begin
               mem_wr_en = 1'b1;
               depth_in  = depth_ff + DEPTH_W'(1);
               res_in    = make_rsp('0, '0, SLOT_BITS'(q_ff), 1'b1, ERR_NONE);
            end
         end
         ST_MUL: begin
            prod_in = PROD_BITS'(idx_ff) * PROD_BITS'(slot_size_ff);
         end
         ST_ADDR: begin
            if (req_ff.kind == KIND_IDX2HND) begin
               res_in = make_rsp(cpu_form, gpu_form, req_ff.slot_index, i2h_ok,
                                 i2h_ok ? ERR_NONE : ERR_RANGE);
            end else begin
               res_in = make_rsp(cpu_form, gpu_form, SLOT_BITS'(idx_ff), 1'b1, ERR_NONE);
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // register writes
   always_comb begin
      cpu_base_in       = cpu_base_ff;
      gpu_base_in       = gpu_base_ff;
      slot_size_in      = slot_size_ff;
      slot_count_in     = slot_count_ff;
      shader_visible_in = shader_visible_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CPU_BASE:       cpu_base_in       = csr_wdata;
            CSR_GPU_BASE:       gpu_base_in       = csr_wdata;
            CSR_SLOT_SIZE:      slot_size_in      = csr_wdata[SIZE_BITS-1:0];
            CSR_SLOT_COUNT:     slot_count_in     = csr_wdata[COUNT_BITS-1:0];
            CSR_SHADER_VISIBLE: shader_visible_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         fresh_ff          <= '0;
         depth_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         cpu_base_ff       <= '0;
         gpu_base_ff       <= '0;
         slot_size_ff      <= SIZE_BITS'(32);
         slot_count_ff     <= COUNT_BITS'(1024);
         shader_visible_ff <= 1'b1;
      end else begin
         state_ff          <= state_in;
         fresh_ff          <= fresh_in;
         depth_ff          <= depth_in;
         rsp_valid_ff      <= rsp_valid_in;
         cpu_base_ff       <= cpu_base_in;
         gpu_base_ff       <= gpu_base_in;
         slot_size_ff      <= slot_size_in;
         slot_count_ff     <= slot_count_in;
         shader_visible_ff <= shader_visible_in;
      end
      req_ff   <= req_in;
      off_ff   <= off_in;
      goff_ff  <= goff_in;
      below_ff <= below_in;
      limit_ff <= limit_in;
      inr_ff   <= inr_in;
      q_ff     <= q_in;
      qs_ff    <= qs_in;
      idx_ff   <= idx_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule

`default_nettype wire

// ----- hw/rtl/dsa_divider.sv -----
// Radix-2 restoring divider: 64-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dsa_divider
   import dsa_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dsa_div_req_type div_req,
   output dsa_div_rsp_type      div_rsp
);

   logic                      busy_ff, busy_in;
   logic [DIV_CNT_BITS-1:0]   count_ff, count_in;
   logic [SIZE_BITS-1:0]      rem_ff, rem_in;
   logic [ADDR_BITS-1:0]      work_ff, work_in;
   logic [SIZE_BITS-1:0]      den_ff, den_in;
   logic [SIZE_BITS:0]        step_num;
   logic [SIZE_BITS:0]        step_diff;
   logic                      step_ge;

   always_comb begin
      step_num  = {rem_ff, work_ff[ADDR_BITS-1]};
      step_ge   = step_num >= {1'b0, den_ff};
      step_diff = step_num - {1'b0, den_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      work_in  = work_ff;
      den_in   = den_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         den_in  = div_req.divisor;
         if (div_req.short_run) begin
            // upper dividend bits are already below the divisor
            rem_in   = div_req.dividend[DIV_SHORT_STEPS +: SIZE_BITS];
            work_in  = {div_req.dividend[DIV_SHORT_STEPS-1:0],
                        {(ADDR_BITS-DIV_SHORT_STEPS){1'b0}}};
            count_in = DIV_CNT_BITS'(DIV_SHORT_STEPS);
         end else begin
            rem_in   = '0;
            work_in  = div_req.dividend;
            count_in = DIV_CNT_BITS'(DIV_LONG_STEPS);
         end
      end else if (busy_ff && count_ff != '0) begin
         // a zero divisor sets every quotient bit
         rem_in   = step_ge ? step_diff[SIZE_BITS-1:0] : step_num[SIZE_BITS-1:0];
         work_in  = {work_ff[ADDR_BITS-2:0], step_ge};
         count_in = count_ff - DIV_CNT_BITS'(1);
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_in;
   end

   always_comb begin
      div_rsp.done      = busy_ff && (count_ff == '0);
      div_rsp.quotient  = work_ff;
      div_rsp.remainder = rem_ff;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dsa_stack_mem.sv -----
// Free-slot stack storage: single-port-write, registered-read memory.
`timescale 1ns / 1ps
`default_nettype none

module dsa_stack_mem
   import dsa_pkg::*;
#(
   parameter int DEPTH  = DSA_MAX_SLOTS,
   parameter int DATA_W = MUL_IDX_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the slot allocator: directed, zero-size, stack-overflow, random and backpressure tests.
`timescale 1ns / 1ps

module tb_top;
   import dsa_pkg::*;

   localparam int QUIET_LIMIT = 4000;  // cycles with no beat on any channel
   localparam int TAIL_CYCLES = 100;
   localparam int SEG_ITEMS   = 70;
   localparam int HOLD_CYCLES = 400;

   localparam logic [63:0] DIR_CPU_BASE = 64'h0000_0000_1000_0000;
   localparam logic [63:0] DIR_GPU_BASE = 64'h8000_0000_0000_0000;
   localparam logic [63:0] DIR_STRIDE   = 64'd64;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   dsa_req_type             req_payload;
   logic                    rsp_valid;
   logic                    rsp_ready;
   dsa_rsp_type             rsp_payload;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [ADDR_BITS-1:0]    csr_wdata;

   // register shadow
   logic [63:0] cfg_cpu_base = '0;
   logic [63:0] cfg_gpu_base = '0;
   logic [15:0] cfg_size     = 16'd32;
   logic [10:0] cfg_count    = 11'd1024;
   logic        cfg_vis      = 1'b1;

   // free-list shadow
   int                   fresh_next  = 0;
   int                   freed_depth = 0;
   logic [SLOT_BITS-1:0] freed_stack [DSA_MAX_SLOTS];

   dsa_rsp_type due_results[$];
   dsa_rsp_type want;
   int          mismatches    = 0;
   int          quiet_cycles  = 0;
   int          send_idle_pct = 16;
   int          recv_idle_pct = 45;
   int          rsp_hold_left = 0;
   int          seg_no        = 0;

   descriptor_slot_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] slot_addr(input logic [63:0] base, input logic [63:0] idx);
      return (base == '0) ? '0 : base + idx * cfg_size;
   endfunction

   function automatic logic [63:0] slot_quot(input logic [63:0] off);
      return (cfg_size == '0) ? '1 : off / cfg_size;
   endfunction

   // Expected result of one request; advances the free-list shadow.
   function automatic dsa_rsp_type slot_result(input dsa_req_type r);
      dsa_rsp_type e;
      logic [63:0] off, q, cnt, idx;
      e   = '0;
      cnt = (cfg_count > DSA_MAX_SLOTS) ? DSA_MAX_SLOTS : cfg_count;
      off = r.cpu_addr - cfg_cpu_base;
      q   = slot_quot(off);
      case (r.kind)
         KIND_ALLOC: begin
            if (freed_depth > 0 || fresh_next < cnt) begin
               if (freed_depth > 0) begin
                  freed_depth--;
                  idx = freed_stack[freed_depth];
               end else begin
                  idx = fresh_next;
                  fresh_next++;
               end
               e.cpu_handle = slot_addr(cfg_cpu_base, idx);
               e.gpu_handle = cfg_vis ? slot_addr(cfg_gpu_base, idx) : '0;
               e.slot_out   = idx[SLOT_BITS-1:0];
               e.ok         = 1'b1;
            end else
               e.error = ERR_EMPTY;
         end
         KIND_FREE: begin
            if (r.cpu_addr < cfg_cpu_base)
               e.error = ERR_RANGE;
            else begin
               e.slot_out = q[SLOT_BITS-1:0];
               if (q >= cnt || (r.gpu_addr != '0 && slot_quot(r.gpu_addr - cfg_gpu_base) != q))
                  e.error = ERR_RANGE;
               else if (freed_depth >= DSA_MAX_SLOTS)
                  e.error = ERR_OVERFLOW;
               else begin
                  freed_stack[freed_depth] = q[SLOT_BITS-1:0];
                  freed_depth++;
                  e.ok = 1'b1;
               end
            end
         end
         KIND_VALIDATE: begin
            if (r.cpu_addr < cfg_cpu_base || off >= cnt * cfg_size ||
                (r.gpu_addr != '0 && r.gpu_addr - cfg_gpu_base != off))
               e.error = ERR_RANGE;
            else begin
               e.slot_out = q[SLOT_BITS-1:0];
               e.ok       = 1'b1;
            end
         end
         KIND_IDX2HND: begin
            // handles are formed even when the index is out of range
            e.cpu_handle = slot_addr(cfg_cpu_base, r.slot_index);
            e.gpu_handle = cfg_vis ? slot_addr(cfg_gpu_base, r.slot_index) : '0;
            e.slot_out   = r.slot_index;
            if (r.slot_index < cnt)
               e.ok = 1'b1;
            else
               e.error = ERR_RANGE;
         end
         KIND_HND2IDX: begin
            if (r.cpu_addr >= cfg_cpu_base && q < cnt) begin
               e.slot_out = q[SLOT_BITS-1:0];
               e.ok       = 1'b1;
            end else
               e.error = ERR_RANGE;
         end
         KIND_REINIT: begin
            fresh_next  = 0;
            freed_depth = 0;
            e.ok        = 1'b1;
         end
         default: e.error = ERR_RANGE;
      endcase
      return e;
   endfunction

   function automatic dsa_req_type mk_req(input dsa_kind_type k, input logic [63:0] ca,
                                          input logic [63:0] ga, input logic [9:0] si);
      dsa_req_type r;
      r.kind       = k;
      r.cpu_addr   = ca;
      r.gpu_addr   = ga;
      r.slot_index = si;
      return r;
   endfunction

   // Mostly well-formed handles of the current heap, with some noise.
   function automatic dsa_req_type rand_req();
      dsa_req_type r;
      int unsigned pick, cnt, mode;
      logic [63:0] idx, ofs;
      cnt  = (cfg_count > DSA_MAX_SLOTS) ? DSA_MAX_SLOTS : cfg_count;
      pick = $urandom_range(99);
      if (pick < 30)
         r.kind = KIND_ALLOC;
      else if (pick < 58)
         r.kind = KIND_FREE;
      else if (pick < 72)
         r.kind = KIND_VALIDATE;
      else if (pick < 84)
         r.kind = KIND_IDX2HND;
      else if (pick < 98)
         r.kind = KIND_HND2IDX;
      else
         r.kind = KIND_REINIT;
      idx = (cnt > 0 && $urandom_range(9) < 8) ? $urandom_range(cnt - 1) : $urandom_range(2047);
      ofs = (cfg_size > 1 && $urandom_range(1) == 1) ? $urandom_range(cfg_size - 1) : 0;
      mode = $urandom_range(19);
      if (mode == 0)
         r.cpu_addr = {$urandom, $urandom};
      else if (mode == 1)
         r.cpu_addr = cfg_cpu_base - 64'($urandom_range(1, 4096));
      else
         r.cpu_addr = cfg_cpu_base + idx * cfg_size + ofs;
      mode = $urandom_range(9);
      if (mode < 4)
         r.gpu_addr = '0;
      else if (mode < 8)
         r.gpu_addr = cfg_gpu_base + (r.cpu_addr - cfg_cpu_base);
      else if (mode == 8)
         r.gpu_addr = cfg_gpu_base + idx * cfg_size;
      else
         r.gpu_addr = {$urandom, $urandom};
      r.slot_index = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'(idx);
      return r;
   endfunction

   function automatic logic [63:0] pick_base();
      case ($urandom_range(3))
         0:       return '0;
         1:       return {$urandom, $urandom};
         2:       return '1 - 64'($urandom);
         default: return {16'($urandom_range(65535)), 48'h0};
      endcase
   endfunction

   // Valid stays up across back-to-back beats; it drops only in a sender gap or a drain.
   task automatic send_req(input dsa_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      due_results.push_back(slot_result(r));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input dsa_csr_type idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CPU_BASE:       cfg_cpu_base = data;
         CSR_GPU_BASE:       cfg_gpu_base = data;
         CSR_SLOT_SIZE:      cfg_size     = data[15:0];
         CSR_SLOT_COUNT:     cfg_count    = data[10:0];
         CSR_SHADER_VISIBLE: cfg_vis      = data[0];
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [63:0] cpu_base, input logic [63:0] gpu_base,
                               input logic [15:0] size, input logic [10:0] count,
                               input logic vis);
      drain();
      csr_write(CSR_CPU_BASE, cpu_base);
      csr_write(CSR_GPU_BASE, gpu_base);
      csr_write(CSR_SLOT_SIZE, 64'(size));
      csr_write(CSR_SLOT_COUNT, 64'(count));
      csr_write(CSR_SHADER_VISIBLE, 64'(vis));
      csr_valid <= 1'b0;
   endtask

   task automatic choose_config();
      logic [15:0] size;
      logic [10:0] count;
      case (seg_no)
         0: write_config(64'h0000_1000_0000_0000, 64'h0000_2000_0000_0000, 16'd1, 11'd1024, 1'b1);
         // high slots wrap past the top of the address space
         1: write_config(64'hFFFF_FFFF_FFC0_0000, 64'hFFFF_0000_0000_0000, 16'hFFFF, 11'd1024,
                         1'b1);
         2: write_config({$urandom, $urandom}, '0, 16'd48, 11'd1, 1'b0);
         3: write_config(64'h1000, 64'h2000, 16'hFFFF, 11'd0, 1'b1);
         default: begin
            case ($urandom_range(3))
               0:       size = 16'd1;
               1:       size = 16'hFFFF;
               default: size = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(3))
               0:       count = 11'($urandom_range(1, 16));
               1:       count = 11'd1024;
               default: count = 11'($urandom_range(1, 1024));
            endcase
            write_config(pick_base(), pick_base(), size, count, 1'($urandom_range(1)));
         end
      endcase
      seg_no++;
   endtask

   task automatic test_directed();
      logic [63:0] cb, gb;
      cb = DIR_CPU_BASE;
      gb = DIR_GPU_BASE;
      // reset registers: null bases give null handles
      send_req(mk_req(KIND_ALLOC, '0, '0, '0));
      send_req(mk_req(KIND_VALIDATE, 64'd160, '0, '0));
      write_config(cb, gb, 16'(DIR_STRIDE), 11'd4, 1'b1);
      send_req(mk_req(KIND_REINIT, '0, '0, '0));
      repeat (5) send_req(mk_req(KIND_ALLOC, '0, '0, '0));  // last one finds the heap empty
      send_req(mk_req(KIND_FREE, cb + 2 * DIR_STRIDE + 5, gb + 2 * DIR_STRIDE + 5, '0));
      send_req(mk_req(KIND_FREE, cb + DIR_STRIDE, '0, '0));
      send_req(mk_req(KIND_FREE, cb + 3 * DIR_STRIDE, gb, '0));
      send_req(mk_req(KIND_FREE, cb - 1, '0, '0));
      send_req(mk_req(KIND_FREE, cb + 4 * DIR_STRIDE, '0, '0));
      send_req(mk_req(KIND_FREE, '1, '1, '1));
      send_req(mk_req(KIND_ALLOC, '0, '0, '0));
      send_req(mk_req(KIND_ALLOC, '0, '0, '0));
      send_req(mk_req(KIND_VALIDATE, cb + 3 * DIR_STRIDE, gb + 3 * DIR_STRIDE, '0));
      send_req(mk_req(KIND_VALIDATE, cb + 3 * DIR_STRIDE, gb + 3 * DIR_STRIDE + 1, '0));
      send_req(mk_req(KIND_VALIDATE, cb + 4 * DIR_STRIDE, '0, '0));
      send_req(mk_req(KIND_IDX2HND, '0, '0, 10'd3));
      send_req(mk_req(KIND_IDX2HND, '1, '1, 10'd1023));
      send_req(mk_req(KIND_IDX2HND, '0, '0, '0));
      send_req(mk_req(KIND_HND2IDX, cb + 2 * DIR_STRIDE + 63, '0, '0));
      send_req(mk_req(KIND_HND2IDX, cb - 1, '0, '0));
      send_req(mk_req(KIND_HND2IDX, cb + 4 * DIR_STRIDE, '0, '0));
      send_req(mk_req(KIND_REINIT, '0, '0, '0));
      send_req(mk_req(KIND_ALLOC, '0, '0, '0));
   endtask

   // Zero stride: every quotient is all ones, no GPU handles.
   task automatic test_zero_size();
      logic [63:0] cb;
      cb = 64'h0000_4000_0000_0000;
      write_config(cb, 64'h0000_5000_0000_0000, 16'd0, 11'd8, 1'b0);
      send_req(mk_req(KIND_REINIT, '0, '0, '0));
      send_req(mk_req(KIND_ALLOC, '0, '0, '0));
      send_req(mk_req(KIND_ALLOC, '0, '0, '0));
      send_req(mk_req(KIND_FREE, cb, '0, '0));
      send_req(mk_req(KIND_VALIDATE, cb, '0, '0));
      send_req(mk_req(KIND_HND2IDX, cb, '0, '0));
      send_req(mk_req(KIND_IDX2HND, '0, '0, 10'd5));
   endtask

   // Double frees until the free stack is full, then a few past it.
   task automatic test_stack_overflow();
      logic [63:0] cb, gb, off;
      cb = 64'h0000_7F00_0000_0000;
      gb = 64'h0000_7E00_0000_0000;
      write_config(cb, gb, 16'd16, 11'd1024, 1'b1);
      send_req(mk_req(KIND_REINIT, '0, '0, '0));
      repeat (DSA_MAX_SLOTS + 4) begin
         off = 64'($urandom_range(1023)) * 16 + 64'($urandom_range(15));
         send_req(mk_req(KIND_FREE, cb + off, ($urandom_range(1) == 1) ? gb + off : '0, '0));
      end
      repeat (6) send_req(mk_req(KIND_ALLOC, '0, '0, '0));
      repeat (2) send_req(mk_req(KIND_FREE, cb + 64'($urandom_range(1023)) * 16, '0, '0));
      send_req(mk_req(KIND_REINIT, '0, '0, '0));
   endtask

   task automatic test_random(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (4) begin
         choose_config();
         repeat (SEG_ITEMS) send_req(rand_req());
      end
   endtask

   // Receiver holds off while requests keep coming, so the input stalls.
   task automatic test_backpressure();
      drain();
      send_idle_pct = 0;
      rsp_hold_left = HOLD_CYCLES;
      repeat (30) send_req(rand_req());
   endtask

   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp_val, got_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_payload);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("cpu_handle", want.cpu_handle, rsp_payload.cpu_handle);
            check_field("gpu_handle", want.gpu_handle, rsp_payload.gpu_handle);
            check_field("slot_out", 64'(want.slot_out), 64'(rsp_payload.slot_out));
            check_field("ok", 64'(want.ok), 64'(rsp_payload.ok));
            check_field("error", 64'(want.error), 64'(rsp_payload.error));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_zero_size();
      test_stack_overflow();
      test_random(16, 45);
      test_random(45, 16);
      test_random(0, 0);
      test_backpressure();
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_divider.sv
hw/rtl/dsa_stack_mem.sv
hw/rtl/descriptor_slot_allocator.sv
sim/tb_top.sv
